// File: hw/rtl/glos_pkg.sv
`default_nettype none

package glos_pkg;

	localparam int FW = 6;
	localparam int NW = 7;
	localparam int GRID_SPAN = 128;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic [1:0] TRACE_CORNER = 2'd0;
	localparam logic [1:0] TRACE_VEDGE  = 2'd1;
	localparam logic [1:0] TRACE_HEDGE  = 2'd2;

	typedef struct packed {
		logic          mode;
		logic [FW-1:0] src_x;
		logic [FW-1:0] src_y;
		logic [FW-1:0] dst_x;
		logic [FW-1:0] dst_y;
		logic [FW-1:0] cell_x;
		logic [FW-1:0] cell_y;
		logic          cell_clear;
	} glos_req_t;

	typedef struct packed {
		logic visible;
		logic gave_up;
	} glos_rsp_t;

	typedef struct packed {
		logic gt;
		logic lt;
	} glos_cmp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_TINIT,
		ST_TLHS,
		ST_STEP,
		ST_TEST,
		ST_DONE
	} glos_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/glos_xmul.sv
`default_nettype none

module glos_xmul #(
	parameter int A_W = 11
) (
	input  wire logic                    clk,
	input  wire logic                    load,
	input  wire logic [A_W-1:0]          a,
	input  wire logic [glos_pkg::NW-1:0] b,
	output glos_pkg::glos_cmp_t          cmp
);

	localparam int P_W = A_W + glos_pkg::NW;

	logic [P_W-1:0] prod;
	logic [P_W-1:0] lhs_q;

	assign prod = P_W'(a) * P_W'(b);

	// load holds the left-hand product; the next op compares against it
	always_ff @(posedge clk) begin
		if (load) begin
			lhs_q <= prod;
		end
	end

	always_comb begin
		cmp.gt = lhs_q > prod;
		cmp.lt = lhs_q < prod;
	end

endmodule

`default_nettype wire

// File: hw/rtl/glos_map.sv
`default_nettype none

module glos_map #(
	parameter  int DEPTH = 4096,
	localparam int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic          wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic               rd_data,
	output logic               sweeping
);

	localparam logic [AW-1:0] LAST_C = AW'(DEPTH - 1);

	logic          mem [DEPTH];
	logic [AW-1:0] clr_q;
	logic          sweeping_q;
	logic          rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			sweeping_q <= 1'b1;
		end else if (sweeping_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == LAST_C) begin
				sweeping_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sweeping_q) begin
			mem[clr_q] <= 1'b0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign sweeping = sweeping_q;

`ifndef SYNTHESIS
	a_sweep_once: assert property (@(posedge clk) disable iff (!arst_n)
		!sweeping_q |=> !sweeping_q)
		else $error("map sweep restarted");
	a_sweep_end: assert property (@(posedge clk) disable iff (!arst_n)
		(sweeping_q && clr_q == LAST_C) |=> !sweeping_q)
		else $error("map sweep did not end at last entry");
	a_no_access_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sweeping_q |-> (!rd_en && !wr_en))
		else $error("map access during sweep");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/grid_line_of_sight.sv
// Write word: taken while busy is low; busy stays low, no done.
// Query word: done strobes in DONE; for the same cell SETUP goes straight to DONE, a vertical path runs
// STEP then TEST per cell, otherwise up to three traces each run TINIT, TLHS, then STEP and TEST per cell.
// Each trace step takes two products on the shared multiply-compare unit and one map read.
// One query in flight; the next start is taken the cycle after done; done cannot be held off.
// Reset: the map sweeps MAP_DIM*MAP_DIM cells to opaque, one per cycle, with busy high.
`default_nettype none

module grid_line_of_sight #(
	parameter int MAP_DIM    = 64,
	parameter int STEP_LIMIT = 256
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire glos_pkg::glos_req_t req,
	output logic                     busy,
	output logic                     done,
	output glos_pkg::glos_rsp_t      rsp
);

	localparam int DEPTH = MAP_DIM * MAP_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(MAP_DIM);
	localparam int CW    = $clog2(glos_pkg::GRID_SPAN + 2*STEP_LIMIT + 2*MAP_DIM + 4) + 1;
	localparam int NCW   = $clog2(STEP_LIMIT + 1);
	localparam int FW    = glos_pkg::FW;
	localparam int NW    = glos_pkg::NW;

	localparam logic signed [CW-1:0] DIM_C   = CW'(MAP_DIM);
	localparam logic signed [CW-1:0] ONE_C   = CW'(1);
	localparam logic signed [CW-1:0] TWO_C   = CW'(2);
	localparam logic [NCW-1:0]       LIMIT_C = NCW'(STEP_LIMIT);

	function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
		return v[CW-1] ? $unsigned(-v) : $unsigned(v);
	endfunction

	function automatic logic in_map(input logic signed [CW-1:0] x,
		input logic signed [CW-1:0] y);
		return !x[CW-1] && !y[CW-1] && (x < DIM_C) && (y < DIM_C);
	endfunction

	function automatic logic [AW-1:0] map_addr(input logic signed [CW-1:0] x,
		input logic signed [CW-1:0] y);
		logic [AW-1:0] xi;
		logic [AW-1:0] yi;
		xi = AW'(x[XW-1:0]);
		yi = AW'(y[XW-1:0]);
		return yi * AW'(MAP_DIM) + xi;
	endfunction

	function automatic logic signed [CW-1:0] dbl(input logic [FW-1:0] f);
		return {{(CW-FW-1){1'b0}}, f, 1'b0};
	endfunction

	glos_pkg::glos_state_t state_q, state_d;

	logic signed [CW-1:0] ox_q, oy_q, tx_q, ty_q, cx_q, cy_q;
	logic [NW-1:0]        num_q, den_q;
	logic [NCW-1:0]       n_q;
	logic [1:0]           trace_q;
	logic                 xneg_q, yneg_q, vert_q, first_q, in_range_q;
	logic                 vis_q, gave_q;

	logic                 acc, sweeping;
	logic signed [CW-1:0] wx, wy, dir_x, dir_y, step_x, step_y, cell_cx, cell_cy;
	logic [CW-1:0]        tn, td, d_a, d_b, n_a, n_b;
	logic                 same, reach, open_c, blocked, limit_hit, fail, last_trace;

	logic                 wr_en, rd_en, rd_data, mul_load;
	logic [AW-1:0]        rd_addr;
	logic [CW-1:0]        mul_a;
	logic [NW-1:0]        mul_b;
	glos_pkg::glos_cmp_t  cmp;

	assign acc = start && !busy;
	assign wx  = {{(CW-FW){1'b0}}, req.cell_x};
	assign wy  = {{(CW-FW){1'b0}}, req.cell_y};
	assign wr_en = acc && (req.mode == glos_pkg::MODE_WRITE) && in_map(wx, wy);

	assign dir_x  = xneg_q ? -ONE_C : ONE_C;
	assign dir_y  = yneg_q ? -ONE_C : ONE_C;
	assign step_x = xneg_q ? -TWO_C : TWO_C;
	assign step_y = yneg_q ? -TWO_C : TWO_C;

	assign tn  = mag(cy_q + dir_y - oy_q);
	assign td  = mag(cx_q + dir_x - ox_q);
	assign d_a = mag(tx_q - dir_x - ox_q);
	assign d_b = mag(tx_q - ox_q);
	assign n_a = mag(ty_q - dir_y - oy_q);
	assign n_b = mag(ty_q - oy_q);

	assign cell_cx = cx_q >>> 1;
	assign cell_cy = cy_q >>> 1;

	assign same       = (ox_q == tx_q) && (oy_q == ty_q);
	assign reach      = (cx_q == tx_q) && (cy_q == ty_q);
	assign open_c     = in_range_q && rd_data;
	assign blocked    = !first_q && !open_c;
	assign limit_hit  = !vert_q && (n_q == LIMIT_C);
	assign fail       = blocked || limit_hit;
	assign last_trace = trace_q == glos_pkg::TRACE_HEDGE;

	glos_map #(
		.DEPTH(DEPTH)
	) u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (map_addr(wx, wy)),
		.wr_data (req.cell_clear),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.sweeping(sweeping)
	);

	glos_xmul #(
		.A_W(CW)
	) u_xmul (
		.clk (clk),
		.load(mul_load),
		.a   (mul_a),
		.b   (mul_b),
		.cmp (cmp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= glos_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			glos_pkg::ST_IDLE: begin
				if (acc && req.mode == glos_pkg::MODE_QUERY) begin
					state_d = glos_pkg::ST_SETUP;
				end
			end
			glos_pkg::ST_SETUP: begin
				if (same) begin
					state_d = glos_pkg::ST_DONE;
				end else if (ox_q == tx_q) begin
					state_d = glos_pkg::ST_STEP;
				end else begin
					state_d = glos_pkg::ST_TINIT;
				end
			end
			glos_pkg::ST_TINIT: state_d = glos_pkg::ST_TLHS;
			glos_pkg::ST_TLHS:  state_d = glos_pkg::ST_STEP;
			glos_pkg::ST_STEP: begin
				if (!fail) begin
					state_d = glos_pkg::ST_TEST;
				end else if (vert_q || last_trace) begin
					state_d = glos_pkg::ST_DONE;
				end else begin
					state_d = glos_pkg::ST_TINIT;
				end
			end
			glos_pkg::ST_TEST: begin
				state_d = reach ? glos_pkg::ST_DONE : glos_pkg::ST_STEP;
			end
			glos_pkg::ST_DONE: state_d = glos_pkg::ST_IDLE;
			default:           state_d = glos_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy     = sweeping || (state_q != glos_pkg::ST_IDLE);
		done     = state_q == glos_pkg::ST_DONE;
		rsp      = '{visible: vis_q, gave_up: gave_q};
		mul_load = (state_q == glos_pkg::ST_TLHS) || (state_q == glos_pkg::ST_TEST);
		mul_a    = (state_q == glos_pkg::ST_STEP) ? td : tn;
		mul_b    = (state_q == glos_pkg::ST_STEP) ? num_q : den_q;
		rd_en    = (state_q == glos_pkg::ST_TEST) && !reach && in_map(cell_cx, cell_cy);
		rd_addr  = map_addr(cell_cx, cell_cy);
	end

	always_ff @(posedge clk) begin
		case (state_q)
			glos_pkg::ST_IDLE: begin
				if (acc && req.mode == glos_pkg::MODE_QUERY) begin
					ox_q <= dbl(req.src_x);
					oy_q <= dbl(req.src_y);
					tx_q <= dbl(req.dst_x);
					ty_q <= dbl(req.dst_y);
				end
			end
			glos_pkg::ST_SETUP: begin
				xneg_q  <= tx_q < ox_q;
				yneg_q  <= ty_q < oy_q;
				vert_q  <= ox_q == tx_q;
				vis_q   <= same;
				gave_q  <= 1'b0;
				cx_q    <= ox_q;
				cy_q    <= oy_q;
				first_q <= 1'b1;
				trace_q <= glos_pkg::TRACE_CORNER;
			end
			glos_pkg::ST_TINIT: begin
				case (trace_q)
					glos_pkg::TRACE_CORNER: begin
						num_q <= NW'(n_a);
						den_q <= NW'(d_a);
					end
					glos_pkg::TRACE_VEDGE: begin
						num_q <= NW'(n_b);
						den_q <= NW'(d_a);
					end
					glos_pkg::TRACE_HEDGE: begin
						num_q <= NW'(n_a);
						den_q <= NW'(d_b);
					end
					default: begin
						num_q <= NW'(n_a);
						den_q <= NW'(d_a);
					end
				endcase
				cx_q    <= ox_q;
				cy_q    <= oy_q;
				n_q     <= '0;
				first_q <= 1'b1;
			end
			glos_pkg::ST_STEP: begin
				if (fail) begin
					if (!blocked) begin
						gave_q <= 1'b1;
					end
					trace_q <= trace_q + 1'b1;
				end else begin
					first_q <= 1'b0;
					if (vert_q) begin
						cy_q <= cy_q + step_y;
					end else if (cmp.gt) begin
						cx_q <= cx_q + step_x;
					end else if (cmp.lt) begin
						cy_q <= cy_q + step_y;
					end else begin
						cx_q <= cx_q + step_x;
						cy_q <= cy_q + step_y;
					end
				end
			end
			glos_pkg::ST_TEST: begin
				if (reach) begin
					vis_q <= 1'b1;
				end
				in_range_q <= in_map(cell_cx, cell_cy);
				if (!vert_q) begin
					n_q <= n_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy after done");
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.mode == glos_pkg::MODE_QUERY) |=> busy)
		else $error("query word not started");
	a_write_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.mode == glos_pkg::MODE_WRITE) |=> (!busy && !done))
		else $error("write word made block busy");
`endif

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int MAP_DIM    = 64;
	localparam int STEP_LIMIT = 256;
	localparam int TAIL       = 2000;

	typedef enum logic [1:0] {RAY_BLOCKED, RAY_REACHED, RAY_GAVE_UP} ray_end_t;

	typedef struct {
		glos_pkg::glos_req_t w;
		bit                  fixed;
		bit                  vis;
	} probe_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	glos_pkg::glos_req_t req = '0;
	logic                busy;
	logic                done;
	glos_pkg::glos_rsp_t rsp;

	bit                  map_bits [MAP_DIM*MAP_DIM];
	glos_pkg::glos_rsp_t pending_views[$];
	probe_t              dir_rows[$];
	bit                  driving = 1'b0;
	bit                  quiet = 1'b0;
	int                  err_count = 0;
	int                  n_items = 0;
	int                  n_writes = 0;
	int                  n_queries = 0;
	int                  n_seen = 0;
	int                  n_vert = 0;
	int                  n_limit = 0;

	grid_line_of_sight u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	always #5 clk = ~clk;

	initial begin
		#50_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	function automatic int mag(int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic int clamp6(int v);
		return (v < 0) ? 0 : (v > MAP_DIM - 1) ? MAP_DIM - 1 : v;
	endfunction

	function automatic bit open_cell(int x, int y);
		if (x < 0 || y < 0 || x >= MAP_DIM || y >= MAP_DIM)
			return 1'b0;
		return map_bits[y*MAP_DIM + x];
	endfunction

	// doubled coordinates; slope num/den picks x, y or diagonal move
	function automatic ray_end_t walk_ray(int num, int den, int sxd, int syd,
			int ox, int oy, int tx, int ty);
		int     cx;
		int     cy;
		longint lhs;
		longint rhs;
		cx = ox;
		cy = oy;
		for (int n = 0; n < STEP_LIMIT; n++) begin
			lhs = longint'(mag(cy + syd - oy)) * den;
			rhs = longint'(num) * mag(cx + sxd - ox);
			if (lhs > rhs) begin
				cx += 2*sxd;
			end else if (lhs < rhs) begin
				cy += 2*syd;
			end else begin
				cx += 2*sxd;
				cy += 2*syd;
			end
			if (cx == tx && cy == ty)
				return RAY_REACHED;
			if (!open_cell(cx / 2, cy / 2))
				return RAY_BLOCKED;
		end
		return RAY_GAVE_UP;
	endfunction

	function automatic glos_pkg::glos_rsp_t sight_query(int sx, int sy, int tx, int ty);
		glos_pkg::glos_rsp_t r;
		int                  dx;
		int                  dy;
		int                  cy;
		int                  nums[3];
		int                  dens[3];
		ray_end_t            e;
		r = '0;
		if (sx == tx && sy == ty) begin
			r.visible = 1'b1;
			return r;
		end
		dx = (tx >= sx) ? 1 : -1;
		dy = (ty >= sy) ? 1 : -1;
		if (sx == tx) begin
			for (cy = sy + dy; cy != ty; cy += dy)
				if (!open_cell(tx, cy))
					return r;
			r.visible = 1'b1;
			return r;
		end
		sx *= 2;
		sy *= 2;
		tx *= 2;
		ty *= 2;
		// corner, vertical edge midpoint, horizontal edge midpoint
		nums = '{mag(ty - dy - sy), mag(ty - sy), mag(ty - dy - sy)};
		dens = '{mag(tx - dx - sx), mag(tx - dx - sx), mag(tx - sx)};
		for (int k = 0; k < 3; k++) begin
			e = walk_ray(nums[k], dens[k], dx, dy, sx, sy, tx, ty);
			if (e == RAY_REACHED) begin
				r.visible = 1'b1;
				return r;
			end
			if (e == RAY_GAVE_UP)
				r.gave_up = 1'b1;
		end
		return r;
	endfunction

	// unused fields carry random bits
	function automatic glos_pkg::glos_req_t wr_word(int x, int y, bit c);
		glos_pkg::glos_req_t w;
		logic [63:0]         rnd;
		rnd = {$urandom, $urandom};
		w = rnd[$bits(glos_pkg::glos_req_t)-1:0];
		w.mode = glos_pkg::MODE_WRITE;
		w.cell_x = x[glos_pkg::FW-1:0];
		w.cell_y = y[glos_pkg::FW-1:0];
		w.cell_clear = c;
		return w;
	endfunction

	function automatic glos_pkg::glos_req_t q_word(int sx, int sy, int tx, int ty);
		glos_pkg::glos_req_t w;
		logic [63:0]         rnd;
		rnd = {$urandom, $urandom};
		w = rnd[$bits(glos_pkg::glos_req_t)-1:0];
		w.mode = glos_pkg::MODE_QUERY;
		w.src_x = sx[glos_pkg::FW-1:0];
		w.src_y = sy[glos_pkg::FW-1:0];
		w.dst_x = tx[glos_pkg::FW-1:0];
		w.dst_y = ty[glos_pkg::FW-1:0];
		return w;
	endfunction

	task automatic set_start(bit v);
		if (driving != v) begin
			start <= v;
			driving = v;
		end
	endtask

	task automatic send_word(glos_pkg::glos_req_t w, bit fixed, bit vis);
		glos_pkg::glos_rsp_t want;
		while (!quiet && $urandom_range(0, 99) < 8) begin
			set_start(1'b0);
			@(posedge clk);
		end
		set_start(1'b1);
		req <= w;
		do @(posedge clk); while (busy !== 1'b0);
		n_items++;
		if (w.mode == glos_pkg::MODE_WRITE) begin
			map_bits[int'(w.cell_y)*MAP_DIM + int'(w.cell_x)] = w.cell_clear;
			n_writes++;
		end else begin
			want = sight_query(w.src_x, w.src_y, w.dst_x, w.dst_y);
			if (fixed)
				want = '{visible: vis, gave_up: 1'b0};
			pending_views.push_back(want);
			n_queries++;
			n_seen += want.visible;
			n_limit += want.gave_up;
			if (w.src_x == w.dst_x && w.src_y != w.dst_y)
				n_vert++;
		end
	endtask

	task automatic drain();
		set_start(1'b0);
		do @(posedge clk); while (pending_views.size() != 0);
	endtask

	always @(posedge clk) begin
		glos_pkg::glos_rsp_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_views.size() == 0) begin
				$display("%0t: unexpected result vis=%0b gave=%0b", $time,
					rsp.visible, rsp.gave_up);
				err_count++;
			end else begin
				want = pending_views.pop_front();
				if (rsp.visible !== want.visible || rsp.gave_up !== want.gave_up) begin
					$display("%0t: mismatch want vis=%0b gave=%0b got vis=%0b gave=%0b",
						$time, want.visible, want.gave_up, rsp.visible, rsp.gave_up);
					err_count++;
				end
			end
		end
	end

	initial begin
		int wx, wy, ox, oy, dens, nq, ep, r, sx, sy, tx, ty, tmp;
		for (int i = 0; i < MAP_DIM*MAP_DIM; i++)
			map_bits[i] = 1'b0;

		// map starts all opaque
		dir_rows.push_back('{q_word(0, 0, 0, 0), 1'b1, 1'b1});
		dir_rows.push_back('{q_word(63, 63, 63, 63), 1'b1, 1'b1});
		dir_rows.push_back('{q_word(0, 0, 63, 63), 1'b1, 1'b0});
		dir_rows.push_back('{q_word(63, 0, 0, 63), 1'b1, 1'b0});
		dir_rows.push_back('{q_word(7, 20, 7, 21), 1'b1, 1'b1});
		dir_rows.push_back('{q_word(7, 21, 7, 20), 1'b1, 1'b1});
		dir_rows.push_back('{q_word(7, 0, 7, 63), 1'b1, 1'b0});
		dir_rows.push_back('{q_word(1, 0, 0, 0), 1'b0, 1'b0});
		dir_rows.push_back('{wr_word(0, 0, 1'b1), 1'b0, 1'b0});
		dir_rows.push_back('{wr_word(0, 1, 1'b1), 1'b0, 1'b0});
		dir_rows.push_back('{wr_word(1, 1, 1'b1), 1'b0, 1'b0});
		dir_rows.push_back('{q_word(0, 0, 2, 2), 1'b0, 1'b0});
		dir_rows.push_back('{q_word(2, 2, 0, 0), 1'b0, 1'b0});
		dir_rows.push_back('{wr_word(63, 63, 1'b1), 1'b0, 1'b0});
		dir_rows.push_back('{wr_word(62, 62, 1'b1), 1'b0, 1'b0});
		dir_rows.push_back('{q_word(61, 61, 63, 63), 1'b0, 1'b0});
		dir_rows.push_back('{q_word(63, 63, 61, 61), 1'b0, 1'b0});
		dir_rows.push_back('{wr_word(10, 5, 1'b1), 1'b0, 1'b0});
		dir_rows.push_back('{wr_word(10, 6, 1'b1), 1'b0, 1'b0});
		dir_rows.push_back('{wr_word(10, 7, 1'b1), 1'b0, 1'b0});
		dir_rows.push_back('{q_word(10, 4, 10, 8), 1'b1, 1'b1});
		dir_rows.push_back('{wr_word(10, 6, 1'b0), 1'b0, 1'b0});
		dir_rows.push_back('{q_word(10, 8, 10, 4), 1'b1, 1'b0});
		dir_rows.push_back('{q_word(0, 0, 63, 0), 1'b0, 1'b0});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_word(dir_rows[i].w, dir_rows[i].fixed, dir_rows[i].vis);
		drain();

		// episodes: open up a window of the map, then look across it
		ep = 0;
		while (n_items < 820) begin
			quiet = (n_items >= 300 && n_items < 450);
			wx = $urandom_range(1, 8);
			wy = $urandom_range(1, 8);
			if ($urandom_range(0, 7) == 0) begin
				wx = $urandom_range(1, 2);
				wy = $urandom_range(16, 64);
				if ($urandom_range(0, 1)) begin
					tmp = wx;
					wx = wy;
					wy = tmp;
				end
			end
			ox = $urandom_range(0, MAP_DIM - wx);
			oy = $urandom_range(0, MAP_DIM - wy);
			dens = $urandom_range(60, 100);
			for (int y = oy; y < oy + wy; y++)
				for (int x = ox; x < ox + wx; x++)
					send_word(wr_word(x, y, $urandom_range(0, 99) < dens), 1'b0, 1'b0);
			nq = $urandom_range(4, 12);
			for (int k = 0; k < nq; k++) begin
				r = $urandom_range(0, 99);
				if (r < 15) begin
					sx = $urandom_range(0, 63);
					sy = $urandom_range(0, 63);
					tx = $urandom_range(0, 63);
					ty = $urandom_range(0, 63);
				end else begin
					sx = clamp6(ox - 1 + $urandom_range(0, wx + 1));
					sy = clamp6(oy - 1 + $urandom_range(0, wy + 1));
					tx = clamp6(ox - 1 + $urandom_range(0, wx + 1));
					ty = clamp6(oy - 1 + $urandom_range(0, wy + 1));
					if (r < 30)
						tx = sx;
					if (r < 35)
						ty = sy;
				end
				send_word(q_word(sx, sy, tx, ty), 1'b0, 1'b0);
				if ($urandom_range(0, 9) == 0)
					send_word(wr_word($urandom_range(0, 63), $urandom_range(0, 63),
						$urandom_range(0, 1)), 1'b0, 1'b0);
			end
			ep++;
			if (ep % 6 == 0)
				drain();
		end

		drain();
		repeat (TAIL) @(posedge clk);
		$display("testbench: %0d words over %0d episodes, %0d writes, %0d queries",
			n_items, ep, n_writes, n_queries);
		$display("testbench: %0d seen, %0d vertical paths, %0d trace limits",
			n_seen, n_vert, n_limit);
		if (err_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/glos_pkg.sv
hw/rtl/glos_xmul.sv
hw/rtl/glos_map.sv
hw/rtl/grid_line_of_sight.sv
verif/testbench.sv
